>>> design/ssi_pkg.sv
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared constants and types for the segment intersection pipeline.
// ----------------------------------------------------------------------------
package ssi_pkg;

    localparam int COORD_BITS_DEF = 16;

    // per-stage control that travels alongside the datapath
    typedef struct packed {
        logic valid;
        logic hit;
        logic neg_x;
        logic neg_y;
    } t_ctl;

endpackage

>>> design/ssi_if.sv
// ----------------------------------------------------------------------------
// ssi_if
// Valid/ready channels for segment pairs in and intersection results out.
// ----------------------------------------------------------------------------
interface ssi_in_if import ssi_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] a_start_x;
    logic signed [COORD_BITS-1:0] a_start_y;
    logic signed [COORD_BITS-1:0] a_end_x;
    logic signed [COORD_BITS-1:0] a_end_y;
    logic signed [COORD_BITS-1:0] b_start_x;
    logic signed [COORD_BITS-1:0] b_start_y;
    logic signed [COORD_BITS-1:0] b_end_x;
    logic signed [COORD_BITS-1:0] b_end_y;

    modport source (
        output valid, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y,
        input  ready
    );
    modport sink (
        input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y,
        output ready
    );
endinterface

interface ssi_out_if import ssi_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic signed [COORD_BITS-1:0] cross_x;
    logic signed [COORD_BITS-1:0] cross_y;

    modport source (output valid, hit, cross_x, cross_y, input ready);
    modport sink   (input valid, hit, cross_x, cross_y, output ready);
endinterface

>>> design/ssi_front.sv
// ----------------------------------------------------------------------------
// ssi_front
// Differences, cross products, denominator and numerators, sign
// normalisation and the hit test, over four register stages.
// ----------------------------------------------------------------------------
module ssi_front import ssi_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_a_start_x,
    input  logic signed [COORD_BITS-1:0] i_a_start_y,
    input  logic signed [COORD_BITS-1:0] i_a_end_x,
    input  logic signed [COORD_BITS-1:0] i_a_end_y,
    input  logic signed [COORD_BITS-1:0] i_b_start_x,
    input  logic signed [COORD_BITS-1:0] i_b_start_y,
    input  logic signed [COORD_BITS-1:0] i_b_end_x,
    input  logic signed [COORD_BITS-1:0] i_b_end_y,
    output t_ctl                         o_ctl,
    output logic [2*COORD_BITS+1:0]      o_den,
    output logic [2*COORD_BITS+1:0]      o_na,
    output logic [COORD_BITS:0]          o_mag_x,
    output logic [COORD_BITS:0]          o_mag_y,
    output logic signed [COORD_BITS-1:0] o_x1,
    output logic signed [COORD_BITS-1:0] o_y1
);

    localparam int DB = COORD_BITS + 1;
    localparam int PB = 2 * COORD_BITS + 2;
    localparam int W  = 2 * COORD_BITS + 3;
    localparam int DW = W - 1;

    // stage 1: differences
    logic                         r1_valid;
    logic signed [DB-1:0]         r1_dxa, r1_dya, r1_dxb, r1_dyb, r1_ox, r1_oy;
    logic signed [COORD_BITS-1:0] r1_x1, r1_y1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dxa <= DB'(i_a_end_x) - DB'(i_a_start_x);
            r1_dya <= DB'(i_a_end_y) - DB'(i_a_start_y);
            r1_dxb <= DB'(i_b_end_x) - DB'(i_b_start_x);
            r1_dyb <= DB'(i_b_end_y) - DB'(i_b_start_y);
            r1_ox  <= DB'(i_a_start_x) - DB'(i_b_start_x);
            r1_oy  <= DB'(i_a_start_y) - DB'(i_b_start_y);
            r1_x1  <= i_a_start_x;
            r1_y1  <= i_a_start_y;
        end
    end

    // stage 2: six products, magnitudes of segment a's run
    t_ctl                         r2_ctl;
    logic signed [PB-1:0]         r2_pd1, r2_pd2, r2_pa1, r2_pa2, r2_pb1, r2_pb2;
    logic [DB-1:0]                r2_mag_x, r2_mag_y;
    logic signed [COORD_BITS-1:0] r2_x1, r2_y1;
    t_ctl                         n2_ctl;

    always_comb begin
        n2_ctl       = '0;
        n2_ctl.valid = r1_valid;
        n2_ctl.neg_x = r1_dxa[DB-1];
        n2_ctl.neg_y = r1_dya[DB-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else if (i_en) begin
            r2_ctl <= n2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_pd1   <= PB'(r1_dyb) * PB'(r1_dxa);
            r2_pd2   <= PB'(r1_dxb) * PB'(r1_dya);
            r2_pa1   <= PB'(r1_dxb) * PB'(r1_oy);
            r2_pa2   <= PB'(r1_dyb) * PB'(r1_ox);
            r2_pb1   <= PB'(r1_dxa) * PB'(r1_oy);
            r2_pb2   <= PB'(r1_dya) * PB'(r1_ox);
            r2_mag_x <= r1_dxa[DB-1] ? DB'(-r1_dxa) : DB'(r1_dxa);
            r2_mag_y <= r1_dya[DB-1] ? DB'(-r1_dya) : DB'(r1_dya);
            r2_x1    <= r1_x1;
            r2_y1    <= r1_y1;
        end
    end

    // stage 3: denominator and numerators
    t_ctl                         r3_ctl;
    logic signed [W-1:0]          r3_den, r3_na, r3_nb;
    logic [DB-1:0]                r3_mag_x, r3_mag_y;
    logic signed [COORD_BITS-1:0] r3_x1, r3_y1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
        end else if (i_en) begin
            r3_ctl <= r2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_den   <= W'(r2_pd1) - W'(r2_pd2);
            r3_na    <= W'(r2_pa1) - W'(r2_pa2);
            r3_nb    <= W'(r2_pb1) - W'(r2_pb2);
            r3_mag_x <= r2_mag_x;
            r3_mag_y <= r2_mag_y;
            r3_x1    <= r2_x1;
            r3_y1    <= r2_y1;
        end
    end

    // stage 4: force a non-negative denominator, then test both parameters
    logic signed [W-1:0] n4_den, n4_na, n4_nb;
    logic [DW-1:0]       n4_den_u;
    t_ctl                n4_ctl;

    always_comb begin
        n4_den   = r3_den[W-1] ? -r3_den : r3_den;
        n4_na    = r3_den[W-1] ? -r3_na : r3_na;
        n4_nb    = r3_den[W-1] ? -r3_nb : r3_nb;
        n4_den_u = n4_den[DW-1:0];
        n4_ctl   = r3_ctl;
        n4_ctl.hit = (r3_den != '0)
                   && !n4_na[W-1] && (n4_na[DW-1:0] <= n4_den_u)
                   && !n4_nb[W-1] && (n4_nb[DW-1:0] <= n4_den_u);
    end

    t_ctl                         r4_ctl;
    logic [DW-1:0]                r4_den, r4_na;
    logic [DB-1:0]                r4_mag_x, r4_mag_y;
    logic signed [COORD_BITS-1:0] r4_x1, r4_y1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_ctl <= '0;
        end else if (i_en) begin
            r4_ctl <= n4_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_den   <= n4_den_u;
            r4_na    <= n4_na[DW-1:0];
            r4_mag_x <= r3_mag_x;
            r4_mag_y <= r3_mag_y;
            r4_x1    <= r3_x1;
            r4_y1    <= r3_y1;
        end
    end

    assign o_ctl   = r4_ctl;
    assign o_den   = r4_den;
    assign o_na    = r4_na;
    assign o_mag_x = r4_mag_x;
    assign o_mag_y = r4_mag_y;
    assign o_x1    = r4_x1;
    assign o_y1    = r4_y1;

endmodule

>>> design/ssi_mul.sv
// ----------------------------------------------------------------------------
// ssi_mul
// Scales the numerator by each run of segment a: two half-width partial
// products per axis, then their sum, over two register stages.
// ----------------------------------------------------------------------------
module ssi_mul import ssi_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  t_ctl                         i_ctl,
    input  logic [2*COORD_BITS+1:0]      i_den,
    input  logic [2*COORD_BITS+1:0]      i_na,
    input  logic [COORD_BITS:0]          i_mag_x,
    input  logic [COORD_BITS:0]          i_mag_y,
    input  logic signed [COORD_BITS-1:0] i_x1,
    input  logic signed [COORD_BITS-1:0] i_y1,
    output t_ctl                         o_ctl,
    output logic [2*COORD_BITS+1:0]      o_den,
    output logic [3*COORD_BITS+2:0]      o_prod_x,
    output logic [3*COORD_BITS+2:0]      o_prod_y,
    output logic signed [COORD_BITS-1:0] o_x1,
    output logic signed [COORD_BITS-1:0] o_y1
);

    localparam int HB = COORD_BITS + 1;
    localparam int PB = 2 * HB;
    localparam int DW = 2 * COORD_BITS + 2;
    localparam int PW = 3 * COORD_BITS + 3;

    // stage 1: partial products
    t_ctl                         r1_ctl;
    logic [PB-1:0]                r1_px_lo, r1_px_hi, r1_py_lo, r1_py_hi;
    logic [DW-1:0]                r1_den;
    logic signed [COORD_BITS-1:0] r1_x1, r1_y1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else if (i_en) begin
            r1_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_px_lo <= PB'(i_na[HB-1:0]) * PB'(i_mag_x);
            r1_px_hi <= PB'(i_na[DW-1:HB]) * PB'(i_mag_x);
            r1_py_lo <= PB'(i_na[HB-1:0]) * PB'(i_mag_y);
            r1_py_hi <= PB'(i_na[DW-1:HB]) * PB'(i_mag_y);
            r1_den   <= i_den;
            r1_x1    <= i_x1;
            r1_y1    <= i_y1;
        end
    end

    // stage 2: recombine the halves
    t_ctl                         r2_ctl;
    logic [PW-1:0]                r2_prod_x, r2_prod_y;
    logic [DW-1:0]                r2_den;
    logic signed [COORD_BITS-1:0] r2_x1, r2_y1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else if (i_en) begin
            r2_ctl <= r1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_prod_x <= PW'(r1_px_lo) + (PW'(r1_px_hi) << HB);
            r2_prod_y <= PW'(r1_py_lo) + (PW'(r1_py_hi) << HB);
            r2_den    <= r1_den;
            r2_x1     <= r1_x1;
            r2_y1     <= r1_y1;
        end
    end

    assign o_ctl    = r2_ctl;
    assign o_den    = r2_den;
    assign o_prod_x = r2_prod_x;
    assign o_prod_y = r2_prod_y;
    assign o_x1     = r2_x1;
    assign o_y1     = r2_y1;

endmodule

>>> design/ssi_div.sv
// ----------------------------------------------------------------------------
// ssi_div
// Pipelined restoring divider for both axes: one quotient bit per stage,
// most significant first, sharing the denominator.
// ----------------------------------------------------------------------------
module ssi_div import ssi_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  t_ctl                         i_ctl,
    input  logic [2*COORD_BITS+1:0]      i_den,
    input  logic [3*COORD_BITS+2:0]      i_prod_x,
    input  logic [3*COORD_BITS+2:0]      i_prod_y,
    input  logic signed [COORD_BITS-1:0] i_x1,
    input  logic signed [COORD_BITS-1:0] i_y1,
    output t_ctl                         o_ctl,
    output logic [2*COORD_BITS+1:0]      o_den,
    output logic [3*COORD_BITS+2:0]      o_rem_x,
    output logic [3*COORD_BITS+2:0]      o_rem_y,
    output logic [COORD_BITS+1:0]        o_q_x,
    output logic [COORD_BITS+1:0]        o_q_y,
    output logic signed [COORD_BITS-1:0] o_x1,
    output logic signed [COORD_BITS-1:0] o_y1
);

    localparam int DW = 2 * COORD_BITS + 2;
    localparam int PW = 3 * COORD_BITS + 3;
    localparam int QW = COORD_BITS + 2;
    localparam int NS = QW;

    t_ctl                         r_ctl   [NS];
    logic [DW-1:0]                r_den   [NS];
    logic [PW-1:0]                r_rem_x [NS];
    logic [PW-1:0]                r_rem_y [NS];
    logic [QW-1:0]                r_q_x   [NS];
    logic [QW-1:0]                r_q_y   [NS];
    logic signed [COORD_BITS-1:0] r_x1    [NS];
    logic signed [COORD_BITS-1:0] r_y1    [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam int SH = NS - 1 - k;

        t_ctl                         ctl_in;
        logic [DW-1:0]                den_in;
        logic [PW-1:0]                rem_x_in, rem_y_in, trial;
        logic [QW-1:0]                q_x_in, q_y_in;
        logic signed [COORD_BITS-1:0] x1_in, y1_in;

        if (k == 0) begin : g_first
            assign ctl_in   = i_ctl;
            assign den_in   = i_den;
            assign rem_x_in = i_prod_x;
            assign rem_y_in = i_prod_y;
            assign q_x_in   = '0;
            assign q_y_in   = '0;
            assign x1_in    = i_x1;
            assign y1_in    = i_y1;
        end else begin : g_next
            assign ctl_in   = r_ctl[k-1];
            assign den_in   = r_den[k-1];
            assign rem_x_in = r_rem_x[k-1];
            assign rem_y_in = r_rem_y[k-1];
            assign q_x_in   = r_q_x[k-1];
            assign q_y_in   = r_q_y[k-1];
            assign x1_in    = r_x1[k-1];
            assign y1_in    = r_y1[k-1];
        end

        // denominator aligned to this stage's quotient bit
        assign trial = PW'(den_in) << SH;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k] <= '0;
            end else if (i_en) begin
                r_ctl[k] <= ctl_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k] <= den_in;
                r_x1[k]  <= x1_in;
                r_y1[k]  <= y1_in;
                if (trial <= rem_x_in) begin
                    r_rem_x[k] <= rem_x_in - trial;
                    r_q_x[k]   <= q_x_in | (QW'(1) << SH);
                end else begin
                    r_rem_x[k] <= rem_x_in;
                    r_q_x[k]   <= q_x_in;
                end
                if (trial <= rem_y_in) begin
                    r_rem_y[k] <= rem_y_in - trial;
                    r_q_y[k]   <= q_y_in | (QW'(1) << SH);
                end else begin
                    r_rem_y[k] <= rem_y_in;
                    r_q_y[k]   <= q_y_in;
                end
            end
        end
    end

    assign o_ctl   = r_ctl[NS-1];
    assign o_den   = r_den[NS-1];
    assign o_rem_x = r_rem_x[NS-1];
    assign o_rem_y = r_rem_y[NS-1];
    assign o_q_x   = r_q_x[NS-1];
    assign o_q_y   = r_q_y[NS-1];
    assign o_x1    = r_x1[NS-1];
    assign o_y1    = r_y1[NS-1];

endmodule

>>> design/segment_segment_intersection.sv
// ----------------------------------------------------------------------------
// segment_segment_intersection
// Exact 2D segment/segment intersection test with truncated crossing point.
// ----------------------------------------------------------------------------
// Takes one pair of segments per clock while the output is not held and
// returns one result per pair, in order: four stages form the cross products
// and the hit test, two scale the numerator, COORD_BITS + 2 stages run the
// restoring divider at one quotient bit each, and one holds the output. The
// divider depth sets the latency; throughput is one pair per cycle unless the
// output stalls. While the result at the output waits, the whole pipeline
// holds, and input ready drops only then. A miss, which includes parallel and
// collinear pairs, gives hit low and a zero point.
module segment_segment_intersection import ssi_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ssi_in_if.sink        i_seg,
    ssi_out_if.source     o_res
);

    localparam int DW = 2 * COORD_BITS + 2;
    localparam int PW = 3 * COORD_BITS + 3;
    localparam int QW = COORD_BITS + 2;

    logic en;

    t_ctl                         fr_ctl;
    logic [DW-1:0]                fr_den, fr_na;
    logic [COORD_BITS:0]          fr_mag_x, fr_mag_y;
    logic signed [COORD_BITS-1:0] fr_x1, fr_y1;

    t_ctl                         ml_ctl;
    logic [DW-1:0]                ml_den;
    logic [PW-1:0]                ml_prod_x, ml_prod_y;
    logic signed [COORD_BITS-1:0] ml_x1, ml_y1;

    t_ctl                         dv_ctl;
    logic [DW-1:0]                dv_den;
    logic [PW-1:0]                dv_rem_x, dv_rem_y;
    logic [QW-1:0]                dv_q_x, dv_q_y;
    logic signed [COORD_BITS-1:0] dv_x1, dv_y1;

    logic                         r_out_valid, r_hit;
    logic signed [COORD_BITS-1:0] r_cross_x, r_cross_y;
    logic [QW-1:0]                n_sum_x, n_sum_y, start_x, start_y;

    // the pipeline moves unless a finished transaction is waiting
    assign en          = !r_out_valid || o_res.ready;
    assign i_seg.ready = en;

    ssi_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_seg.valid),
        .i_a_start_x (i_seg.a_start_x),
        .i_a_start_y (i_seg.a_start_y),
        .i_a_end_x   (i_seg.a_end_x),
        .i_a_end_y   (i_seg.a_end_y),
        .i_b_start_x (i_seg.b_start_x),
        .i_b_start_y (i_seg.b_start_y),
        .i_b_end_x   (i_seg.b_end_x),
        .i_b_end_y   (i_seg.b_end_y),
        .o_ctl       (fr_ctl),
        .o_den       (fr_den),
        .o_na        (fr_na),
        .o_mag_x     (fr_mag_x),
        .o_mag_y     (fr_mag_y),
        .o_x1        (fr_x1),
        .o_y1        (fr_y1)
    );

    ssi_mul #(.COORD_BITS(COORD_BITS)) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_ctl    (fr_ctl),
        .i_den    (fr_den),
        .i_na     (fr_na),
        .i_mag_x  (fr_mag_x),
        .i_mag_y  (fr_mag_y),
        .i_x1     (fr_x1),
        .i_y1     (fr_y1),
        .o_ctl    (ml_ctl),
        .o_den    (ml_den),
        .o_prod_x (ml_prod_x),
        .o_prod_y (ml_prod_y),
        .o_x1     (ml_x1),
        .o_y1     (ml_y1)
    );

    ssi_div #(.COORD_BITS(COORD_BITS)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_ctl    (ml_ctl),
        .i_den    (ml_den),
        .i_prod_x (ml_prod_x),
        .i_prod_y (ml_prod_y),
        .i_x1     (ml_x1),
        .i_y1     (ml_y1),
        .o_ctl    (dv_ctl),
        .o_den    (dv_den),
        .o_rem_x  (dv_rem_x),
        .o_rem_y  (dv_rem_y),
        .o_q_x    (dv_q_x),
        .o_q_y    (dv_q_y),
        .o_x1     (dv_x1),
        .o_y1     (dv_y1)
    );

    // start point plus or minus the truncated offset along segment a
    always_comb begin
        start_x = QW'(dv_x1);
        start_y = QW'(dv_y1);
        n_sum_x = dv_ctl.neg_x ? start_x - dv_q_x : start_x + dv_q_x;
        n_sum_y = dv_ctl.neg_y ? start_y - dv_q_y : start_y + dv_q_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit     <= dv_ctl.hit;
            r_cross_x <= dv_ctl.hit ? n_sum_x[COORD_BITS-1:0] : '0;
            r_cross_y <= dv_ctl.hit ? n_sum_y[COORD_BITS-1:0] : '0;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.hit     = r_hit;
    assign o_res.cross_x = r_cross_x;
    assign o_res.cross_y = r_cross_y;

    // a hit leaving the front end has a nonzero denominator and ua in [0,1]
    a_front_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fr_ctl.valid && fr_ctl.hit |-> (fr_den != '0) && (fr_na <= fr_den))
        else $error("front end hit with ua outside [0,1]");

    // the divider must leave a remainder below the denominator on a hit
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_ctl.valid && dv_ctl.hit |->
            (dv_rem_x < PW'(dv_den)) && (dv_rem_y < PW'(dv_den)))
        else $error("divider remainder not below denominator");

    // a miss transaction carries a zero point
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_hit |-> (r_cross_x == '0) && (r_cross_y == '0))
        else $error("miss transaction with nonzero point");

endmodule

>>> dv/ssi_checker.sv
// ----------------------------------------------------------------------------
// ssi_checker
// Watches both channels of the segment intersection block, predicts the
// hit flag and crossing point of every accepted pair and checks each result
// transaction against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssi_checker import ssi_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ssi_in_if    i_seg,
    ssi_out_if   i_res,
    output int   o_pending,
    output int   o_fail_count
);

    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_start_x;
        logic signed [COORD_BITS-1:0] a_start_y;
        logic signed [COORD_BITS-1:0] a_end_x;
        logic signed [COORD_BITS-1:0] a_end_y;
        logic signed [COORD_BITS-1:0] b_start_x;
        logic signed [COORD_BITS-1:0] b_start_y;
        logic signed [COORD_BITS-1:0] b_end_x;
        logic signed [COORD_BITS-1:0] b_end_y;
    } t_seg_pair;

    typedef struct packed {
        logic                         hit;
        logic signed [COORD_BITS-1:0] cross_x;
        logic signed [COORD_BITS-1:0] cross_y;
    } t_crossing;

    t_crossing crossings_due[$];

    // exact cross products in wide signed arithmetic, quotients toward zero
    function automatic t_crossing predict_crossing(input t_seg_pair p);
        t_wide     x1, y1, x2, y2, x3, y3, x4, y4;
        t_wide     dxa, dya, dxb, dyb, ox, oy;
        t_wide     den, na, nb, qx, qy, cx, cy;
        t_crossing r;
        x1 = $signed(p.a_start_x);
        y1 = $signed(p.a_start_y);
        x2 = $signed(p.a_end_x);
        y2 = $signed(p.a_end_y);
        x3 = $signed(p.b_start_x);
        y3 = $signed(p.b_start_y);
        x4 = $signed(p.b_end_x);
        y4 = $signed(p.b_end_y);
        dxa = x2 - x1;
        dya = y2 - y1;
        dxb = x4 - x3;
        dyb = y4 - y3;
        ox  = x1 - x3;
        oy  = y1 - y3;
        den = dyb * dxa - dxb * dya;
        na  = dxb * oy - dyb * ox;
        nb  = dxa * oy - dya * ox;
        r = '0;
        if (den == 0)
            return r;
        if (den < 0) begin
            den = -den;
            na  = -na;
            nb  = -nb;
        end
        if (na < 0 || na > den || nb < 0 || nb > den)
            return r;
        qx = (na * ((dxa < 0) ? -dxa : dxa)) / den;
        qy = (na * ((dya < 0) ? -dya : dya)) / den;
        cx = (dxa < 0) ? x1 - qx : x1 + qx;
        cy = (dya < 0) ? y1 - qy : y1 + qy;
        r.hit     = 1'b1;
        r.cross_x = cx[COORD_BITS-1:0];
        r.cross_y = cy[COORD_BITS-1:0];
        return r;
    endfunction

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    always @(posedge i_clk) begin
        t_seg_pair pair;
        t_crossing got;
        t_crossing want;
        if (i_rst_n) begin
            if (i_seg.valid && i_seg.ready) begin
                pair.a_start_x = i_seg.a_start_x;
                pair.a_start_y = i_seg.a_start_y;
                pair.a_end_x   = i_seg.a_end_x;
                pair.a_end_y   = i_seg.a_end_y;
                pair.b_start_x = i_seg.b_start_x;
                pair.b_start_y = i_seg.b_start_y;
                pair.b_end_x   = i_seg.b_end_x;
                pair.b_end_y   = i_seg.b_end_y;
                crossings_due.push_back(predict_crossing(pair));
            end
            if (i_res.valid && i_res.ready) begin
                got.hit     = i_res.hit;
                got.cross_x = i_res.cross_x;
                got.cross_y = i_res.cross_y;
                if (crossings_due.size() == 0) begin
                    $error("result transaction with no pair outstanding: hit %0d (%0d, %0d)",
                           got.hit, got.cross_x, got.cross_y);
                    o_fail_count++;
                end else begin
                    want = crossings_due.pop_front();
                    if (got.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, got.hit);
                        o_fail_count++;
                    end
                    if (got.cross_x !== want.cross_x) begin
                        $error("cross_x: expected %0d, got %0d", want.cross_x, got.cross_x);
                        o_fail_count++;
                    end
                    if (got.cross_y !== want.cross_y) begin
                        $error("cross_y: expected %0d, got %0d", want.cross_y, got.cross_y);
                        o_fail_count++;
                    end
                end
            end
            o_pending = crossings_due.size();
        end
    end

endmodule

>>> dv/tb_segment_segment_intersection.sv
// ----------------------------------------------------------------------------
// tb_segment_segment_intersection
// Drives directed and random segment pairs into the intersection block with
// bursty input and a stalling receiver; the checker scores every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_segment_segment_intersection import ssi_pkg::*;;

    localparam int CB          = COORD_BITS_DEF;
    localparam int LATENCY     = CB + 9;
    localparam int RANDOM_ITEMS = 1850;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic signed [CB-1:0] a_start_x;
        logic signed [CB-1:0] a_start_y;
        logic signed [CB-1:0] a_end_x;
        logic signed [CB-1:0] a_end_y;
        logic signed [CB-1:0] b_start_x;
        logic signed [CB-1:0] b_start_y;
        logic signed [CB-1:0] b_end_x;
        logic signed [CB-1:0] b_end_y;
    } t_seg_pair;

    logic i_clk;
    logic i_rst_n;
    int   pending;
    int   fail_count;
    int   cycle_count;

    t_seg_pair pairs_to_send[$];

    ssi_in_if  #(.COORD_BITS(CB)) seg_if ();
    ssi_out_if #(.COORD_BITS(CB)) res_if ();

    segment_segment_intersection #(.COORD_BITS(CB)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_if),
        .o_res   (res_if)
    );

    ssi_checker #(.COORD_BITS(CB)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seg        (seg_if),
        .i_res        (res_if),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic add_pair(input int ax1, input int ay1, input int ax2, input int ay2,
                            input int bx1, input int by1, input int bx2, input int by2);
        t_seg_pair p;
        p.a_start_x = ax1[CB-1:0];
        p.a_start_y = ay1[CB-1:0];
        p.a_end_x   = ax2[CB-1:0];
        p.a_end_y   = ay2[CB-1:0];
        p.b_start_x = bx1[CB-1:0];
        p.b_start_y = by1[CB-1:0];
        p.b_end_x   = bx2[CB-1:0];
        p.b_end_y   = by2[CB-1:0];
        pairs_to_send.push_back(p);
    endtask

    function automatic int any_coord();
        logic signed [CB-1:0] v;
        v = CB'($urandom());
        return int'(v);
    endfunction

    function automatic int near(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic add_random_pair();
        int kind;
        int px, py, dx, dy, ex, ey, m;
        int ax1, ay1, ax2, ay2;
        kind = $urandom_range(0, 9);
        px = near(8000);
        py = near(8000);
        dx = near(3000);
        dy = near(3000);
        ex = near(3000);
        ey = near(3000);
        m  = $urandom_range(0, 3);
        if (kind < 3) begin
            add_pair(any_coord(), any_coord(), any_coord(), any_coord(),
                     any_coord(), any_coord(), any_coord(), any_coord());
        end else if (kind < 5) begin
            // tight grid: parallel, degenerate and touching pairs turn up often
            add_pair(near(6), near(6), near(6), near(6), near(6), near(6), near(6), near(6));
        end else if (kind < 8) begin
            // both segments pass through one point, scaled ends reach the endpoints
            add_pair(px - dx, py - dy, px + dx * m, py + dy * m,
                     px - ex * m, py - ey * m, px + ex, py + ey);
        end else if (kind == 8) begin
            // shared endpoint
            ax1 = px - dx;
            ay1 = py - dy;
            ax2 = px + dx;
            ay2 = py + dy;
            add_pair(ax1, ay1, ax2, ay2, ax2, ay2, ax2 + ex, ay2 + ey);
        end else begin
            // copy of a, shifted by e when m is odd, end nudged by m on both axes; identical to a when m is zero
            add_pair(px, py, px + dx, py + dy, px + ex * (m & 1), py + ey * (m & 1),
                     px + dx + ex * (m & 1) + m, py + dy + ey * (m & 1) + m);
        end
    endtask

    initial begin
        // plain crossing, parallel, collinear overlap, zero-length segments
        add_pair(0, 0, 256, 256, 0, 256, 256, 0);
        add_pair(0, 0, 320, 0, 0, 16, 320, 16);
        add_pair(0, 0, 320, 0, 160, 0, 480, 0);
        add_pair(48, 48, 48, 48, 0, 0, 96, 96);
        add_pair(0, 0, 96, 96, 48, 48, 48, 48);
        // touching: a start on b, a end on b, b start on a, b end on a
        add_pair(0, 0, 100, 50, 0, -40, 0, 40);
        add_pair(-100, -50, 0, 0, 0, -40, 0, 40);
        add_pair(-50, 0, 50, 0, 0, 0, 0, 70);
        add_pair(-50, 0, 50, 0, 0, -70, 0, 0);
        // just short of each other
        add_pair(0, 0, 100, 0, 101, -30, 101, 30);
        add_pair(0, 0, 100, 0, -1, -30, -1, 30);
        // descending direction, truncation toward zero
        add_pair(0, 0, -30, -10, -7, -20, -7, 20);
        add_pair(0, 0, -30, 10, -7, -20, -7, 20);
        // full range
        add_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        add_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
        add_pair(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767);
        add_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        add_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        add_pair(-32768, -32768, 32767, -32768, 32767, -32768, 32767, 32767);
        add_pair(21845, -21846, -21846, 21845, 21845, 21845, -21846, -21846);
        for (int n = 0; n < RANDOM_ITEMS; n++)
            add_random_pair();
    end

    // receiver: runs of always-ready, light and heavy random stalls, hard holds
    initial begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(4, 50);
            end
            left--;
            case (mode)
                0: begin
                    res_if.ready = 1'b1;
                end
                1: begin
                    res_if.ready = ($urandom_range(0, 3) != 0);
                end
                2: begin
                    res_if.ready = ($urandom_range(0, 3) == 0);
                end
                default: begin
                    res_if.ready = 1'b0;
                end
            endcase
        end
    end

    initial begin
        t_seg_pair p;
        int        burst_left;
        seg_if.valid     = 1'b0;
        seg_if.a_start_x = '0;
        seg_if.a_start_y = '0;
        seg_if.a_end_x   = '0;
        seg_if.a_end_y   = '0;
        seg_if.b_start_x = '0;
        seg_if.b_start_y = '0;
        seg_if.b_end_x   = '0;
        seg_if.b_end_y   = '0;
        burst_left = 0;
        i_rst_n    = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        while (pairs_to_send.size() != 0) begin
            if (burst_left == 0) begin
                seg_if.valid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                         : $urandom_range(1, 12);
            end
            burst_left--;
            p = pairs_to_send.pop_front();
            seg_if.a_start_x = p.a_start_x;
            seg_if.a_start_y = p.a_start_y;
            seg_if.a_end_x   = p.a_end_x;
            seg_if.a_end_y   = p.a_end_y;
            seg_if.b_start_x = p.b_start_x;
            seg_if.b_start_y = p.b_start_y;
            seg_if.b_end_x   = p.b_end_x;
            seg_if.b_end_y   = p.b_end_y;
            seg_if.valid     = 1'b1;
            @(posedge i_clk);
            while (!seg_if.ready) @(posedge i_clk);
            @(negedge i_clk);
        end
        seg_if.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
